/* rtl/mmh_pkg.sv */
// ============================================================================
// mmh_pkg
// Shared constants, command codes and control structs of the streaming
// 64-bit Murmur hash block.
// ============================================================================
`default_nettype none

package mmh_pkg;

  // Mixing constant and shift of the hash.
  localparam logic [63:0] MulM    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MulMLo  = MulM[31:0];
  localparam logic [31:0] MulMHi  = MulM[63:32];
  localparam int unsigned ShiftR  = 47;

  // Configuration port.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 64;
  localparam logic        CfgIdxSeed = 1'b0;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_PACK_IN,   // pack the input byte, bump the byte count
    DP_START,     // latch the byte count as the length suffix
    DP_PACK_LEN,  // pack the next length byte, bump the byte count
    DP_LD_PW,     // operand <= packed word, clear packed word
    DP_LD_XS,     // operand <= acc ^ (acc >> 47)
    DP_LD_HX,     // operand <= h ^ acc
    DP_ST_H,      // h <= acc
    DP_LD_HS,     // operand <= h ^ (h >> 47)
    DP_EMIT       // hash <= acc ^ (acc >> 47), restart from the seed
  } dp_op_e;

  // Partial product selection of the shared 32x32 multiplier.
  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL
  } mul_sel_e;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e psel;
    acc_op_e  aop;
  } cmd_t;

  typedef struct packed {
    logic pos7;   // next byte completes a word
    logic pw_nz;  // packed word holds a nonzero value
  } sts_t;

endpackage

`default_nettype wire

/* rtl/mmh_if.sv */
// ============================================================================
// mmh_in_if / mmh_out_if
// Valid/ready channels carrying input items and hash results.
// ============================================================================
`default_nettype none

interface mmh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface mmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

/* rtl/mmh_dp.sv */
// ============================================================================
// mmh_dp
// Datapath: byte packing, length suffix, and a shared 32x32 multiplier
// that builds the low 64 bits of a product by the mixing constant.
// ============================================================================
`default_nettype none

module mmh_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mmh_pkg::cmd_t  cmd_i,
  output mmh_pkg::sts_t       sts_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic [63:0]    seed_i,
  output logic [63:0]         hash_o
);

  logic [63:0] h_q, h_d;
  logic [63:0] pw_q, pw_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] a_q, a_d;
  logic [63:0] p_q, p_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] hash_q, hash_d;

  logic [7:0]  pack_byte;
  logic [5:0]  pack_sh;
  logic [63:0] pw_packed;
  logic [31:0] mul_a, mul_b;

  assign pack_sh   = {cnt_q[2:0], 3'b000};
  assign pack_byte = (cmd_i.op == mmh_pkg::DP_PACK_LEN) ? len_q[7:0] : data_byte_i;
  assign pw_packed = pw_q | (64'(pack_byte) << pack_sh);

  always_comb begin
    case (cmd_i.psel)
      mmh_pkg::MS_LH: begin
        mul_a = a_q[31:0];
        mul_b = mmh_pkg::MulMHi;
      end
      mmh_pkg::MS_HL: begin
        mul_a = a_q[63:32];
        mul_b = mmh_pkg::MulMLo;
      end
      default: begin
        mul_a = a_q[31:0];
        mul_b = mmh_pkg::MulMLo;
      end
    endcase
    p_d = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    case (cmd_i.aop)
      mmh_pkg::ACC_LOAD:   acc_d = p_q;
      mmh_pkg::ACC_ADD_HI: acc_d = acc_q + {p_q[31:0], 32'b0};
      default:             acc_d = acc_q;
    endcase
  end

  always_comb begin
    h_d    = h_q;
    pw_d   = pw_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    a_d    = a_q;
    hash_d = hash_q;
    unique case (cmd_i.op)
      mmh_pkg::DP_PACK_IN: begin
        pw_d  = pw_packed;
        cnt_d = cnt_q + 64'd1;
      end
      mmh_pkg::DP_START: len_d = cnt_q;
      mmh_pkg::DP_PACK_LEN: begin
        pw_d  = pw_packed;
        cnt_d = cnt_q + 64'd1;
        len_d = len_q >> 8;
      end
      mmh_pkg::DP_LD_PW: begin
        a_d  = pw_q;
        pw_d = '0;
      end
      mmh_pkg::DP_LD_XS: a_d = acc_q ^ (acc_q >> mmh_pkg::ShiftR);
      mmh_pkg::DP_LD_HX: a_d = h_q ^ acc_q;
      mmh_pkg::DP_ST_H:  h_d = acc_q;
      mmh_pkg::DP_LD_HS: a_d = h_q ^ (h_q >> mmh_pkg::ShiftR);
      mmh_pkg::DP_EMIT: begin
        hash_d = acc_q ^ (acc_q >> mmh_pkg::ShiftR);
        h_d    = seed_i;
        pw_d   = '0;
        cnt_d  = '0;
      end
      default: ;
    endcase
  end

  // Hash state carries architectural reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      pw_q  <= '0;
      cnt_q <= '0;
    end else begin
      h_q   <= h_d;
      pw_q  <= pw_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    a_q    <= a_d;
    p_q    <= p_d;
    acc_q  <= acc_d;
    hash_q <= hash_d;
  end

  assign sts_o.pos7  = (cnt_q[2:0] == 3'd7);
  assign sts_o.pw_nz = (pw_q != '0);
  assign hash_o      = hash_q;

endmodule

`default_nettype wire

/* rtl/mmh_ctrl.sv */
// ============================================================================
// mmh_ctrl
// Controller: sequences byte packing, word folds, the length suffix, the
// final mix and the output register handshake.
// ============================================================================
`default_nettype none

module mmh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_func_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output mmh_pkg::cmd_t      cmd_o,
  input  wire mmh_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PACK_SUF,
    ST_FOLD_LD,
    ST_MUL,
    ST_XS_LD,
    ST_HX_LD,
    ST_H_ST,
    ST_FIN_CHK,
    ST_FIN_LD,
    ST_EMIT
  } state_e;

  // Which multiply is in flight decides where the sequence continues.
  typedef enum logic [1:0] {
    PH_K1,
    PH_K2,
    PH_H,
    PH_FIN
  } phase_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  mstep_q, mstep_d;
  logic [3:0]  suf_q, suf_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    mstep_d    = mstep_q;
    suf_d      = suf_q;
    fin_d      = fin_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: mmh_pkg::DP_NOP, psel: mmh_pkg::MS_LL, aop: mmh_pkg::ACC_NONE};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_func_i) begin
            cmd_o.op = mmh_pkg::DP_PACK_IN;
            if (sts_i.pos7) begin
              state_d = ST_FOLD_LD;
            end
          end else begin
            cmd_o.op = mmh_pkg::DP_START;
            suf_d    = 4'd8;
            fin_d    = 1'b1;
            state_d  = ST_PACK_SUF;
          end
        end
      end
      ST_PACK_SUF: begin
        cmd_o.op = mmh_pkg::DP_PACK_LEN;
        suf_d    = suf_q - 4'd1;
        if (sts_i.pos7) begin
          state_d = ST_FOLD_LD;
        end else if (suf_q == 4'd1) begin
          state_d = ST_FIN_CHK;
        end
      end
      ST_FOLD_LD: begin
        cmd_o.op = mmh_pkg::DP_LD_PW;
        phase_d  = PH_K1;
        mstep_d  = 2'd0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        // Partial products are registered in the cycle before accumulation.
        unique case (mstep_q)
          2'd0: cmd_o.psel = mmh_pkg::MS_LL;
          2'd1: begin
            cmd_o.psel = mmh_pkg::MS_LH;
            cmd_o.aop  = mmh_pkg::ACC_LOAD;
          end
          2'd2: begin
            cmd_o.psel = mmh_pkg::MS_HL;
            cmd_o.aop  = mmh_pkg::ACC_ADD_HI;
          end
          default: cmd_o.aop = mmh_pkg::ACC_ADD_HI;
        endcase
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd3) begin
          unique case (phase_q)
            PH_K1:   state_d = ST_XS_LD;
            PH_K2:   state_d = ST_HX_LD;
            PH_H:    state_d = ST_H_ST;
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_XS_LD: begin
        cmd_o.op = mmh_pkg::DP_LD_XS;
        phase_d  = PH_K2;
        mstep_d  = 2'd0;
        state_d  = ST_MUL;
      end
      ST_HX_LD: begin
        cmd_o.op = mmh_pkg::DP_LD_HX;
        phase_d  = PH_H;
        mstep_d  = 2'd0;
        state_d  = ST_MUL;
      end
      ST_H_ST: begin
        cmd_o.op = mmh_pkg::DP_ST_H;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (suf_q != 4'd0) begin
          state_d = ST_PACK_SUF;
        end else begin
          state_d = ST_FIN_CHK;
        end
      end
      ST_FIN_CHK: begin
        state_d = sts_i.pw_nz ? ST_FOLD_LD : ST_FIN_LD;
      end
      ST_FIN_LD: begin
        cmd_o.op = mmh_pkg::DP_LD_HS;
        phase_d  = PH_FIN;
        mstep_d  = 2'd0;
        state_d  = ST_MUL;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = mmh_pkg::DP_EMIT;
          fin_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.op == mmh_pkg::DP_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_K1;
      mstep_q     <= 2'd0;
      suf_q       <= 4'd0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      mstep_q     <= mstep_d;
      suf_q       <= suf_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/murmur64_stream_hash.sv */
// ============================================================================
// murmur64_stream_hash
// Streaming modified 64-bit Murmur hash with a length suffix.
// ============================================================================
// Usage: message bytes arrive one per transfer on the input channel with
// func = 0; a transfer with func = 1 closes the message and produces one
// transfer on the output channel carrying the 64-bit hash. The seed register
// is written through the APB port at byte address 0 and is loaded into the
// running hash after every finish.
// Bytes: a byte that does not complete a word is taken while the block is
// idle. A byte that completes a word starts a word fold, and no new bytes
// are taken until it ends, since the fold runs three 64-bit multiplies on
// one shared 32x32 multiplier, each built from partial products. A finish
// packs the eight length bytes as a suffix, runs one or two folds (two when
// a nonzero partial word remains after the suffix) and then the final mix
// with one more multiply, whose result goes to the output register.
// Reset: the running hash, packed word and byte count clear and the seed
// register returns to zero; no result is pending.
// Stall: the hash sits in an output register, so new bytes are taken while
// it waits; a later finish holds in its last step until that register frees.
// ============================================================================
`default_nettype none

module murmur64_stream_hash (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mmh_in_if.sink                              in_i,
  mmh_out_if.source                           out_o,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [mmh_pkg::ApbAddrW-1:0]   paddr_i,
  input  wire logic [mmh_pkg::ApbDataW-1:0]   pwdata_i,
  output logic      [mmh_pkg::ApbDataW-1:0]   prdata_o,
  output logic                                pready_o
);

  mmh_pkg::cmd_t cmd;
  mmh_pkg::sts_t sts;

  logic [63:0] seed_q, seed_d;
  logic        cfg_wr;
  logic        seed_sel;

  // Registers are 64 bits wide and sit on 8-byte boundaries, so bit 3 of
  // the address selects the register; the seed is the only one.
  assign seed_sel = (paddr_i[3] == mmh_pkg::CfgIdxSeed);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = seed_sel ? seed_q : '0;
  assign seed_d   = (cfg_wr && seed_sel) ? pwdata_i : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  mmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mmh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (in_i.data_byte),
    .seed_i      (seed_q),
    .hash_o      (out_o.hash_value)
  );

endmodule

`default_nettype wire
